>>> hdl/mdpt_pkg.sv
`default_nettype none
package mdpt_pkg;

  localparam int COORD_BITS = 24;
  localparam int THR_W      = 50;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 1;

  localparam int APB_DW = 64;
  localparam int APB_AW = 4;
  // Register index sits above the byte offset of a 64-bit register
  localparam int REG_IDX_LSB = 3;
  localparam logic [APB_AW-REG_IDX_LSB-1:0] REG_MIN_DIST = '0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_in;
  } pt_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kept_x;
    logic signed [COORD_BITS-1:0] kept_y;
    logic                         last_out;
    logic                         overflowed;
  } pt_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

endpackage
`default_nettype wire

>>> hdl/mdpt_dist.sv
`default_nettype none
module mdpt_dist #(
  parameter int IDX_W = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cand_valid,
  input  wire logic [IDX_W-1:0]            cand_idx,
  input  wire mdpt_pkg::point_t            pivot,
  input  wire mdpt_pkg::point_t            cand,
  input  wire logic [mdpt_pkg::THR_W-1:0]  thr,
  output logic                             hit,
  output logic [IDX_W-1:0]                 hit_idx,
  output logic                             busy
);

  logic [mdpt_pkg::DIFF_W-1:0] dx, dy, ax, ay;
  logic [mdpt_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [mdpt_pkg::SQ_W-1:0]   sx_r, sy_r;
  logic [mdpt_pkg::SUM_W-1:0]  sum, thr_ext;
  logic                        v1_r, v2_r;
  logic [IDX_W-1:0]            idx1_r, idx2_r;

  assign dx = {pivot.x[mdpt_pkg::COORD_BITS-1], pivot.x}
            - {cand.x[mdpt_pkg::COORD_BITS-1], cand.x};
  assign dy = {pivot.y[mdpt_pkg::COORD_BITS-1], pivot.y}
            - {cand.y[mdpt_pkg::COORD_BITS-1], cand.y};
  assign ax = dx[mdpt_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign ay = dy[mdpt_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cand_valid;
      v2_r <= v1_r;
    end
    dx_r   <= ax;
    dy_r   <= ay;
    idx1_r <= cand_idx;
    sx_r   <= dx_r * dx_r;
    sy_r   <= dy_r * dy_r;
    idx2_r <= idx1_r;
  end

  assign sum     = {1'b0, sx_r} + {1'b0, sy_r};
  assign thr_ext = {{(mdpt_pkg::SUM_W - mdpt_pkg::THR_W){1'b0}}, thr};
  assign hit     = v2_r && (sum < thr_ext);
  assign hit_idx = idx2_r;
  assign busy    = v1_r || v2_r;

endmodule
`default_nettype wire

>>> hdl/min_distance_point_thinning.sv
// Loading: one point per cycle, busy stays low until the closing point.
// Thinning: one compare per cycle through the single read port of the point memory,
// with a drain of the distance pipeline after each pivot.
// Output: at most one survivor per cycle; the final one carries last_out.
// Reset (rst_n low, synchronous) clears the set, the removal marks and the threshold.
// The receiver cannot stall: every result is a one-cycle transfer.
`default_nettype none
module min_distance_point_thinning #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire mdpt_pkg::pt_in_t             in_item,
  output logic                              busy,
  output logic                              out_valid,
  output mdpt_pkg::pt_out_t                 out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mdpt_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mdpt_pkg::APB_DW-1:0]  pwdata,
  output logic [mdpt_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE, S_OUTER, S_PIV, S_INNER, S_DRAIN, S_EMIT, S_FLUSH, S_DONE
  } state_t;

  state_t                          state_r;
  logic [CNT_W-1:0]                cnt_r, idx_r, j_r;
  logic                            ovf_r;
  logic [MAX_POINTS-1:0]           marks_r;
  logic [mdpt_pkg::THR_W-1:0]      thr_r;
  mdpt_pkg::point_t                mem [MAX_POINTS];
  mdpt_pkg::point_t                rd_data_r, piv_r, pend_r, wdata;
  logic                            mem_we, mem_re;
  logic [IDX_W-1:0]                mem_raddr;
  logic                            rdi_v_r, rde_v_r, rde_keep_r, pend_v_r;
  logic [IDX_W-1:0]                rdi_j_r;
  logic                            accept, cfg_sel, cfg_wr;
  logic                            dist_hit, dist_busy;
  logic [IDX_W-1:0]                dist_idx;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Configuration
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[mdpt_pkg::APB_AW-1:mdpt_pkg::REG_IDX_LSB] == mdpt_pkg::REG_MIN_DIST);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {{(mdpt_pkg::APB_DW - mdpt_pkg::THR_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr) begin
      thr_r <= pwdata[mdpt_pkg::THR_W-1:0];
    end
  end

  // Point memory
  assign wdata.x = in_item.point_x;
  assign wdata.y = in_item.point_y;
  assign mem_we  = accept && (cnt_r < FULL);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_r[IDX_W-1:0];
    unique case (state_r)
      S_OUTER: mem_re = (idx_r != cnt_r) && !marks_r[idx_r[IDX_W-1:0]];
      S_INNER: begin
        mem_re    = (j_r != cnt_r);
        mem_raddr = j_r[IDX_W-1:0];
      end
      S_EMIT:  mem_re = (idx_r != cnt_r);
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  mdpt_dist #(.IDX_W(IDX_W)) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (rdi_v_r),
    .cand_idx   (rdi_j_r),
    .pivot      (piv_r),
    .cand       (rd_data_r),
    .thr        (thr_r),
    .hit        (dist_hit),
    .hit_idx    (dist_idx),
    .busy       (dist_busy)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      idx_r      <= '0;
      j_r        <= '0;
      ovf_r      <= 1'b0;
      marks_r    <= '0;
      rdi_v_r    <= 1'b0;
      rde_v_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rdi_v_r   <= 1'b0;
      rde_v_r   <= 1'b0;
      out_valid <= 1'b0;

      if (dist_hit) begin
        marks_r[dist_idx] <= 1'b1;
      end

      // Hold one survivor back so the final one can carry last_out
      if (rde_v_r && rde_keep_r) begin
        if (pend_v_r) begin
          out_valid           <= 1'b1;
          out_item.kept_x     <= pend_r.x;
          out_item.kept_y     <= pend_r.y;
          out_item.last_out   <= 1'b0;
          out_item.overflowed <= ovf_r;
        end
        pend_r   <= rd_data_r;
        pend_v_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (cnt_r < FULL) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_item.last_in) begin
              idx_r   <= '0;
              state_r <= S_OUTER;
            end
          end
        end
        S_OUTER: begin
          if (idx_r == cnt_r) begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end else if (marks_r[idx_r[IDX_W-1:0]]) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= S_PIV;
          end
        end
        S_PIV: begin
          piv_r   <= rd_data_r;
          j_r     <= idx_r + 1'b1;
          state_r <= S_INNER;
        end
        S_INNER: begin
          if (j_r == cnt_r) begin
            state_r <= S_DRAIN;
          end else begin
            rdi_v_r <= 1'b1;
            rdi_j_r <= j_r[IDX_W-1:0];
            j_r     <= j_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait for all marks of this pivot before checking the next one
          if (!rdi_v_r && !dist_busy) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_OUTER;
          end
        end
        S_EMIT: begin
          if (idx_r == cnt_r) begin
            state_r <= S_FLUSH;
          end else begin
            rde_v_r    <= 1'b1;
            rde_keep_r <= !marks_r[idx_r[IDX_W-1:0]];
            idx_r      <= idx_r + 1'b1;
          end
        end
        S_FLUSH: begin
          out_valid           <= 1'b1;
          out_item.kept_x     <= pend_r.x;
          out_item.kept_y     <= pend_r.y;
          out_item.last_out   <= 1'b1;
          out_item.overflowed <= ovf_r;
          pend_v_r            <= 1'b0;
          state_r             <= S_DONE;
        end
        S_DONE: begin
          cnt_r   <= '0;
          ovf_r   <= 1'b0;
          marks_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer outside a thinning run");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_out) |=> !out_valid)
    else $error("result transfer after the final survivor");

  a_full_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cnt_r == FULL)) |=> ovf_r)
    else $error("point dropped on a full store without overflow flag");

  a_hit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    dist_hit |-> (state_r == S_INNER || state_r == S_DRAIN))
    else $error("removal mark outside the compare phase");

  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> pend_v_r)
    else $error("set closed without a survivor");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int MAX_PTS      = 64;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 250;
  localparam int C_MAX = 2 ** (mdpt_pkg::COORD_BITS - 1) - 1;
  localparam int C_MIN = -(2 ** (mdpt_pkg::COORD_BITS - 1));
  localparam logic [mdpt_pkg::APB_AW-1:0] ADDR_MIN_DIST =
    mdpt_pkg::APB_AW'(mdpt_pkg::REG_MIN_DIST) << mdpt_pkg::REG_IDX_LSB;
  // next register slot, which holds nothing
  localparam logic [mdpt_pkg::APB_AW-1:0] ADDR_SPARE =
    mdpt_pkg::APB_AW'(1) << mdpt_pkg::REG_IDX_LSB;
  localparam logic [mdpt_pkg::THR_W-1:0] THR_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  mdpt_pkg::pt_in_t in_item = '0;
  logic busy;
  logic out_valid;
  mdpt_pkg::pt_out_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mdpt_pkg::APB_AW-1:0] paddr = '0;
  logic [mdpt_pkg::APB_DW-1:0] pwdata = '0;
  logic [mdpt_pkg::APB_DW-1:0] prdata;
  logic pready;

  // predictor state
  logic [mdpt_pkg::THR_W-1:0] min_dist_sq = '0;
  mdpt_pkg::point_t set_pts[MAX_PTS];
  int set_count = 0;
  bit set_ovf = 1'b0;

  mdpt_pkg::pt_in_t point_feed[$];
  mdpt_pkg::pt_out_t survivors_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  min_distance_point_thinning #(.MAX_POINTS(MAX_PTS)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .out_valid(out_valid), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[min_distance_point_thinning] ERROR");
      $finish;
    end
  end

  function void report_bad(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic longint unsigned dist_sq(mdpt_pkg::point_t a, mdpt_pkg::point_t b);
    longint dx;
    longint dy;
    dx = a.x;
    dx -= b.x;
    dy = a.y;
    dy -= b.y;
    return dx * dx + dy * dy;
  endfunction

  // store one waypoint; on the closing one thin the set and queue its survivors
  function automatic void accept_waypoint(mdpt_pkg::pt_in_t p);
    bit gone[MAX_PTS];
    int last_kept;
    mdpt_pkg::pt_out_t r;
    if (set_count < MAX_PTS) begin
      set_pts[set_count].x = p.point_x;
      set_pts[set_count].y = p.point_y;
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (!p.last_in) return;
    foreach (gone[i]) gone[i] = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      if (gone[i]) continue;
      for (int j = i + 1; j < set_count; j++)
        if (!gone[j] && dist_sq(set_pts[i], set_pts[j]) < min_dist_sq) gone[j] = 1'b1;
    end
    last_kept = 0;
    for (int i = 0; i < set_count; i++)
      if (!gone[i]) last_kept = i;
    for (int i = 0; i < set_count; i++) begin
      if (gone[i]) continue;
      r.kept_x = set_pts[i].x;
      r.kept_y = set_pts[i].y;
      r.last_out = (i == last_kept);
      r.overflowed = set_ovf;
      survivors_q = {survivors_q, r};
    end
    set_count = 0;
    set_ovf = 1'b0;
  endfunction

  // driver: bursts of transfers with random gaps, hold while busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) accept_waypoint(in_item);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (point_feed.size() > 0) begin
          in_item <= point_feed.pop_front();
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is a transfer
  always @(posedge clk) begin
    mdpt_pkg::pt_out_t want;
    if (rst_n && out_valid) begin
      if (survivors_q.size() == 0) begin
        report_bad($sformatf("unexpected result x=%0d y=%0d", out_item.kept_x,
                             out_item.kept_y));
      end else begin
        want = survivors_q.pop_front();
        if (out_item.kept_x !== want.kept_x || out_item.kept_y !== want.kept_y ||
            out_item.last_out !== want.last_out ||
            out_item.overflowed !== want.overflowed)
          report_bad($sformatf("survivor mismatch: got x=%0d y=%0d last=%0b ovf=%0b, %s",
                               out_item.kept_x, out_item.kept_y, out_item.last_out,
                               out_item.overflowed,
                               $sformatf("want x=%0d y=%0d last=%0b ovf=%0b",
                                         want.kept_x, want.kept_y, want.last_out,
                                         want.overflowed)));
      end
    end
  end

  task automatic cfg_write(input logic [mdpt_pkg::APB_AW-1:0] addr,
                           input logic [mdpt_pkg::APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if ((addr >> mdpt_pkg::REG_IDX_LSB) == mdpt_pkg::REG_MIN_DIST)
      min_dist_sq = data[mdpt_pkg::THR_W-1:0];
    @(negedge clk);
    if (pready !== 1'b1) report_bad("pready low");
    if ((addr >> mdpt_pkg::REG_IDX_LSB) == mdpt_pkg::REG_MIN_DIST &&
        prdata !== mdpt_pkg::APB_DW'(min_dist_sq))
      report_bad($sformatf("register readback: got %0h want %0h", prdata,
                           mdpt_pkg::APB_DW'(min_dist_sq)));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (point_feed.size() != 0 || start || survivors_q.size() != 0 || set_count != 0);
    repeat (12) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  function automatic void add_point(int x, int y, bit last);
    mdpt_pkg::pt_in_t p;
    p.point_x = x[mdpt_pkg::COORD_BITS-1:0];
    p.point_y = y[mdpt_pkg::COORD_BITS-1:0];
    p.last_in = last;
    point_feed = {point_feed, p};
  endfunction

  initial begin
    int n_items;
    int set_no;
    int set_size;
    int spread;
    int cx;
    int cy;
    int pick;
    logic [mdpt_pkg::THR_W-1:0] thr;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // threshold still at its reset value of zero: nothing removed
    add_point(C_MAX, C_MIN, 1'b1);
    add_point(C_MIN, C_MIN, 1'b0);
    add_point(C_MAX, C_MAX, 1'b0);
    add_point(0, 0, 1'b0);
    add_point(-1, -1, 1'b1);
    add_point(5, 5, 1'b0);
    add_point(5, 5, 1'b1);
    wait_idle();

    // widest threshold: only the first point of a set survives
    cfg_write(ADDR_MIN_DIST, mdpt_pkg::APB_DW'(THR_MAX));
    add_point(C_MIN, C_MIN, 1'b0);
    add_point(C_MAX, C_MAX, 1'b0);
    add_point(C_MIN, C_MAX, 1'b1);
    wait_idle();

    // duplicates drop, a point at exactly the spacing stays
    cfg_write(ADDR_MIN_DIST, 1);
    add_point(7, -7, 1'b0);
    add_point(7, -7, 1'b0);
    add_point(7, -7, 1'b0);
    add_point(8, -7, 1'b1);
    wait_idle();

    // a removed point must not remove others; spare slot write is dropped
    cfg_write(ADDR_MIN_DIST, 5);
    cfg_write(ADDR_SPARE, 0);
    add_point(0, 0, 1'b0);
    add_point(2, 0, 1'b0);
    add_point(4, 0, 1'b1);

    n_items = 0;
    set_no = 0;
    spread = 100;
    while (n_items < RANDOM_ITEMS) begin
      if (set_no % 4 == 0) begin
        wait_idle();
        spread = $urandom_range(1, 3000);
        pick = $urandom_range(0, 7);
        if (pick == 0) thr = '0;
        else if (pick == 1) thr = THR_MAX;
        else if (pick == 2) thr = mdpt_pkg::THR_W'({$urandom(), $urandom()});
        else thr = mdpt_pkg::THR_W'(longint'(spread) * spread * $urandom_range(1, 12) / 4);
        cfg_write(ADDR_MIN_DIST, mdpt_pkg::APB_DW'(thr));
      end
      if (set_no == 2) set_size = MAX_PTS;
      else if (set_no == 5 || set_no == 13) set_size = $urandom_range(MAX_PTS + 1, MAX_PTS + 4);
      else if ($urandom_range(0, 9) == 0) set_size = $urandom_range(16, 40);
      else set_size = $urandom_range(1, 10);
      cx = $urandom();
      cy = $urandom();
      for (int k = 0; k < set_size; k++) begin
        if ($urandom_range(0, 6) == 0)
          add_point($urandom(), $urandom(), k == set_size - 1);
        else
          add_point(cx + int'($urandom_range(0, 2 * spread)) - spread,
                    cy + int'($urandom_range(0, 2 * spread)) - spread, k == set_size - 1);
      end
      n_items += set_size;
      set_no++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (survivors_q.size() != 0)
      report_bad($sformatf("%0d survivors never arrived", survivors_q.size()));
    if (errors == 0) begin
      $display("[min_distance_point_thinning] OK");
    end else begin
      $display("[min_distance_point_thinning] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
